### rtl/core/radix_number_converter_core_assert.svh
// Assertion macros shared by the converter RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef RADIX_NUMBER_CONVERTER_CORE_ASSERT_SVH
`define RADIX_NUMBER_CONVERTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define RNC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define RNC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define RNC_ASSERT_ALWAYS(lbl, expr, msg)
`define RNC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/rnc_pkg.sv
`default_nettype none

package rnc_pkg;

  localparam int IntBits      = 48;
  localparam int FracInDigits = 11;
  localparam int FracOutDigits = 10;
  localparam int MaxBase      = 36;

  localparam int CharW   = 8;
  localparam int BaseW   = 6;
  localparam int DigitW  = 6;
  localparam int FracW   = 64;
  localparam int ProdW   = FracW + BaseW;
  localparam int NintW   = $clog2(IntBits + 1);
  localparam int RamAw   = $clog2(IntBits);
  localparam int BcntW   = $clog2(IntBits);
  localparam int FidxW   = $clog2(FracOutDigits);
  localparam int NfracW  = $clog2(FracOutDigits + 1);
  localparam int NtakenW = $clog2(FracInDigits + 1);
  localparam int ShW     = $clog2(BaseW);
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgFromBase = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgToBase   = 1'b1;

  localparam logic [BaseW-1:0] FromBaseRst = BaseW'(10);
  localparam logic [BaseW-1:0] ToBaseRst   = BaseW'(2);

  localparam logic [CharW-1:0] CharMinus  = 8'h2D;
  localparam logic [CharW-1:0] CharPoint  = 8'h2E;
  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharNine   = 8'h39;
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } rnc_in_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             last_out;
    logic             overflow;
  } rnc_out_t;

  typedef struct packed {
    logic              ok;
    logic [DigitW-1:0] val;
  } rnc_sym_t;

  function automatic logic [BaseW-1:0] clamp_base(input logic [BaseW-1:0] b);
    logic [BaseW-1:0] r;
    r = b;
    if (b < BaseW'(2)) begin
      r = BaseW'(2);
    end else if (b > BaseW'(MaxBase)) begin
      r = BaseW'(MaxBase);
    end
    return r;
  endfunction

  function automatic rnc_sym_t sym_value(input logic [CharW-1:0] c);
    rnc_sym_t s;
    s.ok  = 1'b1;
    s.val = '0;
    case (c) inside
      [CharZero:CharNine]:     s.val = DigitW'(c - CharZero);
      [CharUpperA:CharUpperZ]: s.val = DigitW'(c - CharUpperA + 8'd10);
      [CharLowerA:CharLowerZ]: s.val = DigitW'(c - CharLowerA + 8'd10);
      default:                 s.ok  = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] r;
    if (d < DigitW'(10)) begin
      r = CharZero + CharW'(d);
    end else begin
      r = CharUpperA + CharW'(d) - 8'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/rnc_ram.sv
`default_nettype none

module rnc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/radix_number_converter_core.sv
// Each source character takes a take step, plus a denominator multiply for a kept fraction digit.
// The last character then computes the 10 fraction digits
// (one multiply and 6 compare-subtract steps each), then each integer digit
// (bit-serial long division over 48 bits), then emits the output beats.
// Everything runs through one shared multiplier and one shared subtractor.
// Reset is asynchronous, active low; it loads the register defaults and clears the number.
`default_nettype none
`include "radix_number_converter_core_assert.svh"

module radix_number_converter_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire rnc_pkg::rnc_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output rnc_pkg::rnc_out_t                  out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rnc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rnc_pkg::BaseW-1:0]     cfg_wdata_i
);

  import rnc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_TAKE   = 13'b0000000000010,
    S_MDEN   = 13'b0000000000100,
    S_FMUL   = 13'b0000000001000,
    S_FDIV   = 13'b0000000010000,
    S_ICHK   = 13'b0000000100000,
    S_IDIV   = 13'b0000001000000,
    S_OSIGN  = 13'b0000010000000,
    S_OZERO  = 13'b0000100000000,
    S_ORD    = 13'b0001000000000,
    S_OINT   = 13'b0010000000000,
    S_OPOINT = 13'b0100000000000,
    S_OFRAC  = 13'b1000000000000
  } state_e;

  state_e               state_q, state_d;
  logic [BaseW-1:0]     from_base_q, from_base_d, to_base_q, to_base_d;
  rnc_in_t              in_q, in_d;
  logic                 neg_q, neg_d, fmode_q, fmode_d, seen_q, seen_d, ovf_q, ovf_d;
  logic [IntBits-1:0]   ival_q, ival_d;
  logic [FracW-1:0]     num_q, num_d, den_q, den_d, rem_q, rem_d;
  logic [NtakenW-1:0]   ntaken_q, ntaken_d;
  logic [ShW-1:0]       sh_q, sh_d;
  logic [DigitW-1:0]    quo_q, quo_d;
  logic [FidxW-1:0]     fidx_q, fidx_d;
  logic [NfracW-1:0]    nfrac_q, nfrac_d;
  logic [DigitW-1:0]    frac_q [FracOutDigits];
  logic [DigitW-1:0]    frac_d [FracOutDigits];
  logic [BcntW-1:0]     bcnt_q, bcnt_d;
  logic [NintW-1:0]     nint_q, nint_d;
  logic [RamAw-1:0]     oidx_q, oidx_d;
  logic                 out_valid_q, out_valid_d;
  rnc_out_t             out_q, out_d;

  logic [BaseW-1:0]     base_in, base_out, mul_b;
  rnc_sym_t             sv;
  logic                 digit_ok, int_sat;
  logic [FracW-1:0]     mul_a;
  logic [ProdW-1:0]     prod, acc_sum;
  logic [FracW-1:0]     sub_a, sub_b, rem_step;
  logic [FracW:0]       diff;
  logic                 borrow;
  logic                 emit_v, emit_last, emit_go, out_free, in_acc, clr;
  logic [CharW-1:0]     emit_char;
  logic                 ram_we;
  logic [DigitW-1:0]    ram_rdata;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign base_in  = clamp_base(from_base_q);
  assign base_out = clamp_base(to_base_q);
  assign sv       = sym_value(in_q.char_code);
  assign digit_ok = sv.ok && (sv.val < base_in);

  always_comb begin
    case (state_q)
      S_TAKE:  mul_a = fmode_q ? num_q : FracW'(ival_q);
      S_MDEN:  mul_a = den_q;
      default: mul_a = rem_q;
    endcase
  end

  assign mul_b   = (state_q == S_FMUL) ? base_out : base_in;
  assign prod    = ProdW'(mul_a) * ProdW'(mul_b);
  assign acc_sum = prod + ProdW'(sv.val);
  assign int_sat = |acc_sum[ProdW-1:IntBits];

  always_comb begin
    if (state_q == S_IDIV) begin
      sub_a = FracW'({rem_q[DigitW-1:0], ival_q[IntBits-1]});
      sub_b = FracW'(base_out);
    end else begin
      sub_a = rem_q;
      sub_b = den_q << sh_q;
    end
  end

  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = diff[FracW];
  assign rem_step = borrow ? sub_a : diff[FracW-1:0];

  always_comb begin
    emit_v    = 1'b0;
    emit_last = 1'b0;
    emit_char = CharZero;
    case (state_q)
      S_OSIGN: begin
        emit_v    = neg_q && ((nint_q != '0) || (nfrac_q != '0));
        emit_char = CharMinus;
      end
      S_OZERO: begin
        emit_v    = 1'b1;
        emit_last = (nfrac_q == '0);
      end
      S_OINT: begin
        emit_v    = 1'b1;
        emit_char = digit_char(ram_rdata);
        emit_last = (oidx_q == '0) && (nfrac_q == '0);
      end
      S_OPOINT: begin
        emit_v    = 1'b1;
        emit_char = CharPoint;
      end
      S_OFRAC: begin
        emit_v    = 1'b1;
        emit_char = digit_char(frac_q[fidx_q]);
        emit_last = (NfracW'(fidx_q) == nfrac_q - 1'b1);
      end
      default: emit_v = 1'b0;
    endcase
  end

  assign emit_go = emit_v && out_free;
  assign clr     = emit_go && emit_last;

  always_comb begin
    state_d     = state_q;
    from_base_d = from_base_q;
    to_base_d   = to_base_q;
    in_d        = in_q;
    neg_d       = neg_q;
    fmode_d     = fmode_q;
    seen_d      = seen_q;
    ovf_d       = ovf_q;
    ival_d      = ival_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    ntaken_d    = ntaken_q;
    sh_d        = sh_q;
    quo_d       = quo_q;
    fidx_d      = fidx_q;
    nfrac_d     = nfrac_q;
    frac_d      = frac_q;
    bcnt_d      = bcnt_q;
    nint_d      = nint_q;
    oidx_d      = oidx_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == CfgFromBase) begin
        from_base_d = cfg_wdata_i;
      end else if (cfg_idx_i == CfgToBase) begin
        to_base_d = cfg_wdata_i;
      end
    end

    if (emit_go) begin
      out_valid_d       = 1'b1;
      out_d.out_char    = emit_char;
      out_d.last_out    = emit_last;
      out_d.overflow    = ovf_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_d    = in_data_i;
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        seen_d  = 1'b1;
        state_d = in_q.last_char ? S_FMUL : S_IDLE;
        if (in_q.char_code == CharMinus) begin
          if (!seen_q) begin
            neg_d = 1'b1;
          end
        end else if (in_q.char_code == CharPoint) begin
          fmode_d = 1'b1;
        end else if (digit_ok) begin
          if (!fmode_q) begin
            ival_d = int_sat ? '1 : acc_sum[IntBits-1:0];
            if (int_sat) begin
              ovf_d = 1'b1;
            end
          end else if (ntaken_q < NtakenW'(FracInDigits)) begin
            num_d   = acc_sum[FracW-1:0];
            state_d = S_MDEN;
          end
        end
        rem_d   = num_q;
        fidx_d  = '0;
        nfrac_d = '0;
      end
      S_MDEN: begin
        den_d    = prod[FracW-1:0];
        ntaken_d = ntaken_q + 1'b1;
        rem_d    = num_q;
        fidx_d   = '0;
        nfrac_d  = '0;
        state_d  = in_q.last_char ? S_FMUL : S_IDLE;
      end
      S_FMUL: begin
        rem_d   = prod[FracW-1:0];
        sh_d    = ShW'(BaseW - 1);
        quo_d   = '0;
        state_d = S_FDIV;
      end
      S_FDIV: begin
        rem_d = rem_step;
        quo_d = {quo_q[DigitW-2:0], !borrow};
        sh_d  = sh_q - 1'b1;
        if (sh_q == '0) begin
          frac_d[fidx_q] = quo_d;
          if (quo_d != '0) begin
            nfrac_d = NfracW'(fidx_q) + 1'b1;
          end
          if (fidx_q == FidxW'(FracOutDigits - 1)) begin
            nint_d  = '0;
            state_d = S_ICHK;
          end else begin
            fidx_d  = fidx_q + 1'b1;
            state_d = S_FMUL;
          end
        end
      end
      S_ICHK: begin
        rem_d  = '0;
        bcnt_d = '0;
        state_d = (ival_q == '0) ? S_OSIGN : S_IDIV;
      end
      S_IDIV: begin
        rem_d  = rem_step;
        ival_d = {ival_q[IntBits-2:0], !borrow};
        bcnt_d = bcnt_q + 1'b1;
        if (bcnt_q == BcntW'(IntBits - 1)) begin
          ram_we  = 1'b1;
          nint_d  = nint_q + 1'b1;
          state_d = S_ICHK;
        end
      end
      S_OSIGN: begin
        if (emit_go || !emit_v) begin
          oidx_d  = RamAw'(nint_q - 1'b1);
          state_d = (nint_q == '0) ? S_OZERO : S_ORD;
        end
      end
      S_OZERO: begin
        if (emit_go) begin
          state_d = (nfrac_q != '0) ? S_OPOINT : S_IDLE;
        end
      end
      S_ORD: begin
        state_d = S_OINT;
      end
      S_OINT: begin
        if (emit_go) begin
          if (oidx_q == '0) begin
            state_d = (nfrac_q != '0) ? S_OPOINT : S_IDLE;
          end else begin
            oidx_d  = oidx_q - 1'b1;
            state_d = S_ORD;
          end
        end
      end
      S_OPOINT: begin
        if (emit_go) begin
          fidx_d  = '0;
          state_d = S_OFRAC;
        end
      end
      S_OFRAC: begin
        if (emit_go) begin
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            fidx_d = fidx_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (clr) begin
      neg_d    = 1'b0;
      fmode_d  = 1'b0;
      seen_d   = 1'b0;
      ovf_d    = 1'b0;
      ival_d   = '0;
      num_d    = '0;
      den_d    = FracW'(1);
      ntaken_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      from_base_q <= FromBaseRst;
      to_base_q   <= ToBaseRst;
      neg_q       <= 1'b0;
      fmode_q     <= 1'b0;
      seen_q      <= 1'b0;
      ovf_q       <= 1'b0;
      ival_q      <= '0;
      num_q       <= '0;
      den_q       <= FracW'(1);
      ntaken_q    <= '0;
      sh_q        <= '0;
      fidx_q      <= '0;
      nfrac_q     <= '0;
      bcnt_q      <= '0;
      nint_q      <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      from_base_q <= from_base_d;
      to_base_q   <= to_base_d;
      neg_q       <= neg_d;
      fmode_q     <= fmode_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      ival_q      <= ival_d;
      num_q       <= num_d;
      den_q       <= den_d;
      ntaken_q    <= ntaken_d;
      sh_q        <= sh_d;
      fidx_q      <= fidx_d;
      nfrac_q     <= nfrac_d;
      bcnt_q      <= bcnt_d;
      nint_q      <= nint_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    frac_q <= frac_d;
    out_q  <= out_d;
  end

  rnc_ram #(
    .Width(DigitW),
    .Depth(IntBits)
  ) u_digit_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(nint_q[RamAw-1:0]),
    .wdata_i(rem_step[DigitW-1:0]),
    .raddr_i(oidx_q),
    .rdata_o(ram_rdata)
  );

  // The denominator is a product of radices and can never reach zero.
  `RNC_ASSERT_ALWAYS(a_den_nonzero, den_q != '0, "fraction denominator is zero")
  // Between characters the held fraction stays a proper fraction.
  `RNC_ASSERT_IMPL(a_frac_proper, state_q == S_IDLE, num_q < den_q, "fraction not proper")
  `RNC_ASSERT_IMPL(a_ovf_sat, ovf_q && (state_q == S_IDLE), &ival_q,
                   "overflow set without saturated integer")
  `RNC_ASSERT_IMPL(a_frac_digit, (state_q == S_FDIV) && (sh_q == '0),
                   quo_d < DigitW'(base_out), "fraction digit not below output radix")
  `RNC_ASSERT_IMPL(a_int_rem, state_q == S_IDIV, rem_q < FracW'(base_out),
                   "partial remainder not below output radix")

endmodule

`default_nettype wire

### tb/sv/radix_number_converter_core_test.sv
`default_nettype none

module radix_number_converter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rnc_pkg::*;

  localparam logic [63:0] IntMax = (64'd1 << IntBits) - 64'd1;
  localparam string SymbolSet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall_o;
  rnc_in_t             in_data = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  rnc_out_t            out_data_o;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CfgFromBase;
  logic [BaseW-1:0]    cfg_wdata = '0;

  radix_number_converter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Register copies and number state of the converter as predicted.
  logic [BaseW-1:0] src_radix = FromBaseRst;
  logic [BaseW-1:0] dst_radix = ToBaseRst;
  bit               num_negative;
  bit               num_in_fraction;
  bit               num_started;
  logic [63:0]      int_acc;
  logic [63:0]      frac_num;
  logic [63:0]      frac_den = 64'd1;
  int unsigned      frac_taken;
  bit               num_saturated;

  rnc_out_t    expected_text [$];
  rnc_in_t     char_q [$];

  int unsigned errors;
  int unsigned items_queued;
  int unsigned chars_taken;
  int unsigned beats_checked;
  int unsigned numbers_rendered;
  int unsigned saturated_numbers;
  int unsigned settings_used;

  bit          in_fire_q;
  int unsigned burst_left = 1;
  int unsigned gap_left;
  int unsigned stall_pct;
  int unsigned mode_timer;
  int unsigned hold_left;
  bit          hold_done;

  function automatic logic [63:0] clamp_radix(input logic [BaseW-1:0] b);
    if (b < 2) return 64'd2;
    if (b > MaxBase) return 64'(MaxBase);
    return 64'(b);
  endfunction

  function automatic int unsigned char_value(input logic [7:0] c);
    if (c >= CharZero && c <= CharNine) return 32'(c - CharZero);
    if (c >= CharUpperA && c <= CharUpperZ) return c - CharUpperA + 10;
    if (c >= CharLowerA && c <= CharLowerZ) return c - CharLowerA + 10;
    return 255;
  endfunction

  function automatic logic [7:0] symbol_char(input int unsigned d, input bit lower);
    logic [7:0] c;
    c = SymbolSet[d];
    if (lower && d >= 10) c = c - CharUpperA + CharLowerA;
    return c;
  endfunction

  function automatic void clear_number();
    num_negative    = 1'b0;
    num_in_fraction = 1'b0;
    num_started     = 1'b0;
    int_acc         = '0;
    frac_num        = '0;
    frac_den        = 64'd1;
    frac_taken      = 0;
    num_saturated   = 1'b0;
  endfunction

  function automatic void render_number();
    rnc_out_t    line [64];
    int unsigned frac_dig [FracOutDigits];
    int unsigned int_dig [IntBits];
    logic [63:0] radix;
    logic [63:0] v;
    logic [63:0] num;
    logic [63:0] p;
    int          nint;
    int          nfrac;
    int          k;
    int          i;
    radix = clamp_radix(dst_radix);
    num = frac_num;
    for (i = 0; i < FracOutDigits; i++) begin
      p = num * radix;
      frac_dig[i] = int'(p / frac_den);
      num = p % frac_den;
    end
    nfrac = FracOutDigits;
    while (nfrac > 0 && frac_dig[nfrac-1] == 0) nfrac--;
    v = int_acc;
    nint = 0;
    while (v != 0 && nint < IntBits) begin
      int_dig[nint] = int'(v % radix);
      v = v / radix;
      nint++;
    end
    k = 0;
    if (num_negative && (nint > 0 || nfrac > 0)) begin
      line[k].out_char = CharMinus;
      k++;
    end
    if (nint == 0) begin
      line[k].out_char = CharZero;
      k++;
    end
    for (i = nint - 1; i >= 0; i--) begin
      line[k].out_char = SymbolSet[int_dig[i]];
      k++;
    end
    if (nfrac > 0) begin
      line[k].out_char = CharPoint;
      k++;
      for (i = 0; i < nfrac; i++) begin
        line[k].out_char = SymbolSet[frac_dig[i]];
        k++;
      end
    end
    for (i = 0; i < k; i++) begin
      line[i].last_out = (i == k - 1);
      line[i].overflow = num_saturated;
      expected_text = {expected_text, line[i]};
    end
    numbers_rendered++;
    if (num_saturated) saturated_numbers++;
  endfunction

  function automatic void take_source_char(input rnc_in_t beat);
    logic [63:0] radix;
    logic [63:0] t;
    int unsigned dv;
    bit          first;
    radix = clamp_radix(src_radix);
    dv = char_value(beat.char_code);
    first = !num_started;
    num_started = 1'b1;
    if (beat.char_code == CharMinus) begin
      if (first) num_negative = 1'b1;
    end else if (beat.char_code == CharPoint) begin
      num_in_fraction = 1'b1;
    end else if (dv < radix) begin
      if (!num_in_fraction) begin
        t = int_acc * radix + dv;
        if (t > IntMax) begin
          t = IntMax;
          num_saturated = 1'b1;
        end
        int_acc = t;
      end else if (frac_taken < FracInDigits) begin
        frac_num = frac_num * radix + dv;
        frac_den = frac_den * radix;
        frac_taken++;
      end
    end
    chars_taken++;
    if (beat.last_char) begin
      render_number();
      clear_number();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 200) $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_beat(input rnc_out_t got);
    rnc_out_t want;
    if (expected_text.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat, char 0x%02h", got.out_char));
      return;
    end
    want = expected_text.pop_front();
    if (got.out_char !== want.out_char)
      report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h", got.out_char, want.out_char));
    if (got.last_out !== want.last_out)
      report_mismatch($sformatf("last_out %b, expected %b on char 0x%02h",
                                got.last_out, want.last_out, want.out_char));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %b, expected %b on char 0x%02h",
                                got.overflow, want.overflow, want.out_char));
    beats_checked++;
  endtask

  always @(posedge clk_i) begin
    in_fire_q = rst_ni && in_valid && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall) check_beat(out_data_o);
    if (in_fire_q) take_source_char(in_data);
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fire_q)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (char_q.size() != 0) begin
        in_data <= char_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (mode_timer == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        mode_timer = $urandom_range(100, 400);
      end else begin
        mode_timer--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && beats_checked >= 40 && out_valid_o && in_valid) begin
        hold_done = 1'b1;
        hold_left = 600;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [BaseW-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgFromBase) src_radix = val;
    else dst_radix = val;
  endtask

  task automatic push_char(input logic [7:0] c, input bit last);
    rnc_in_t beat;
    beat.char_code = c;
    beat.last_char = last;
    char_q = {char_q, beat};
    items_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] junk_char(input int unsigned fb);
    case ($urandom_range(0, 3))
      0: return CharMinus;
      1: return CharPoint;
      2: if (fb < MaxBase) return symbol_char($urandom_range(fb, MaxBase - 1),
                                              1'($urandom_range(0, 1)));
      default: ;
    endcase
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_random_number();
    logic [7:0]  s [$];
    int unsigned fb;
    int unsigned n;
    int unsigned v;
    bit          zeros;
    fb = 32'(clamp_radix(src_radix));
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) s = {s, 8'($urandom_range(0, 255))};
    end else begin
      if ($urandom_range(0, 2) == 0) s = {s, CharMinus};
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 11) == 0) s = {s, junk_char(fb)};
        s = {s, symbol_char($urandom_range(0, fb - 1), 1'($urandom_range(0, 1)))};
      end
      if ($urandom_range(0, 2) != 0) begin
        s = {s, CharPoint};
        zeros = ($urandom_range(0, 3) == 0);
        n = $urandom_range(0, 14);
        repeat (n) begin
          if ($urandom_range(0, 11) == 0) s = {s, junk_char(fb)};
          if (zeros && $urandom_range(0, 7) != 0) v = 0;
          else v = $urandom_range(0, fb - 1);
          s = {s, symbol_char(v, 1'($urandom_range(0, 1)))};
        end
      end
      if (s.size() == 0) s = {s, symbol_char($urandom_range(0, fb - 1), 1'b0)};
    end
    for (int i = 0; i < s.size(); i++) push_char(s[i], i == s.size() - 1);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (char_q.size() != 0 || in_valid || expected_text.size() != 0);
    repeat (100) @(negedge clk_i);
  endtask

  initial begin
    logic [BaseW-1:0] f;
    logic [BaseW-1:0] t;
    int unsigned      target;
    clear_number();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset radices: negative zero, stray minus and second point, a lone junk byte.
    settings_used++;
    push_text("-0");
    push_text("5-.5.7");
    push_char(8'hFF, 1'b1);
    wait_idle();

    // Saturating integer with mixed upper and lower case digits.
    write_reg(CfgFromBase, 6'd36);
    write_reg(CfgToBase, 6'd36);
    settings_used++;
    push_text("zZZZZZZZZZ");
    wait_idle();

    // Radices clamped from below and above.
    write_reg(CfgFromBase, 6'd0);
    write_reg(CfgToBase, 6'd63);
    settings_used++;
    push_text("-1.1");
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin f = 6'd2;  t = 6'd36; end
        1: begin f = 6'd36; t = 6'd2;  end
        2: begin f = 6'd16; t = 6'd10; end
        3: begin f = 6'd10; t = 6'd16; end
        4: begin f = 6'd63; t = 6'd0;  end
        5: begin f = 6'd1;  t = 6'd37; end
        default: begin
          f = 6'($urandom_range(0, 63));
          t = 6'($urandom_range(0, 63));
        end
      endcase
      write_reg(CfgFromBase, f);
      write_reg(CfgToBase, t);
      settings_used++;
      target = items_queued + 42;
      while (items_queued < target) queue_random_number();
      wait_idle();
    end

    $display("Sent %0d characters forming %0d numbers (%0d saturated) over %0d radix settings.",
             chars_taken, numbers_rendered, saturated_numbers, settings_used);
    $display("Checked %0d result beats; long output hold-off applied: %0d.",
             beats_checked, hold_done);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d result beats still expected.", expected_text.size());
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
